@@ rtl/core/fde_pkg.sv @@
package fde_pkg;

  // ascii codes the formatter recognizes or emits
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;

  // most digits a 32-bit value needs (decimal)
  localparam int unsigned DIGIT_MAX = 10;
  localparam int unsigned DIGIT_AW  = 4;

  // ceil(2^35 / 10): floor(v * DEC_RECIP / 2^35) == v / 10 for any 32-bit v
  localparam logic [31:0] DEC_RECIP = 32'hcccc_cccd;
  localparam int unsigned DEC_SHIFT = 35;

  // micro-program addresses
  typedef logic [3:0] uaddr_t;
  localparam uaddr_t U_IDLE   = 4'd0;
  localparam uaddr_t U_DISP   = 4'd1;
  localparam uaddr_t U_ECHO   = 4'd2;
  localparam uaddr_t U_ARGC   = 4'd3;
  localparam uaddr_t U_LITPCT = 4'd4;
  localparam uaddr_t U_NEG    = 4'd5;
  localparam uaddr_t U_DEC    = 4'd6;
  localparam uaddr_t U_HEX    = 4'd7;
  localparam uaddr_t U_MUL    = 4'd8;
  localparam uaddr_t U_DIV    = 4'd9;
  localparam uaddr_t U_EMIT   = 4'd10;
  localparam uaddr_t U_END    = 4'd11;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_LOAD,
    DP_LOAD_NEG,
    DP_MUL,
    DP_DIV,
    DP_POP
  } dp_op_t;

  typedef enum logic [2:0] {
    E_NONE,
    E_FMT,
    E_ARG,
    E_PCT,
    E_MINUS,
    E_DIGIT,
    E_TOTAL
  } emit_t;

  typedef enum logic [2:0] {
    SEQ_WAIT,
    SEQ_DISP,
    SEQ_JUMP,
    SEQ_IF_MORE,
    SEQ_IF_DIGITS
  } seq_t;

  typedef struct packed {
    emit_t  emit;
    dp_op_t op;
    logic   hex;
    logic   fin;
    logic   upd_pct;
    seq_t   seq;
    uaddr_t target;
  } uword_t;

  typedef struct packed {
    dp_op_t      op;
    logic        hex;
    logic [31:0] arg;
  } dp_ctl_t;

  typedef struct packed {
    logic       more;
    logic       last_digit;
    logic [7:0] digit_ch;
  } dp_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'b0, d};
    end else begin
      ch = CH_LOW_A + {4'b0, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage

@@ rtl/core/fde_digit_unit.sv @@
module fde_digit_unit (
  input  logic             clk,
  input  logic             rst,
  input  fde_pkg::dp_ctl_t ctl,
  output fde_pkg::dp_stat_t st
);

  logic [31:0] val;
  logic        hex;
  logic [63:0] prod;
  logic [fde_pkg::DIGIT_AW-1:0] cnt;
  logic [3:0]  dig_mem [fde_pkg::DIGIT_MAX];

  logic [31:0] q;
  logic [31:0] q_ten;
  logic [31:0] diff;
  logic [3:0]  rem;
  logic [fde_pkg::DIGIT_AW-1:0] top_idx;

  // quotient and remainder from the registered product (decimal) or a nibble shift (hex)
  always_comb begin
    if (hex) begin
      q   = {4'b0, val[31:4]};
    end else begin
      q   = 32'(prod[63:fde_pkg::DEC_SHIFT]);
    end
    q_ten = {q[28:0], 3'b0} + {q[30:0], 1'b0};
    diff  = val - q_ten;
    rem   = hex ? val[3:0] : diff[3:0];
  end

  assign top_idx       = cnt - 1'b1;
  assign st.more       = (q != 32'd0);
  assign st.last_digit = (cnt == fde_pkg::DIGIT_AW'(1));
  assign st.digit_ch   = fde_pkg::digit_char(dig_mem[top_idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      unique case (ctl.op)
        fde_pkg::DP_LOAD, fde_pkg::DP_LOAD_NEG: cnt <= '0;
        fde_pkg::DP_DIV:                        cnt <= cnt + 1'b1;
        fde_pkg::DP_POP:                        cnt <= cnt - 1'b1;
        default:                                cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      fde_pkg::DP_LOAD: begin
        val <= ctl.arg;
        hex <= ctl.hex;
      end
      fde_pkg::DP_LOAD_NEG: begin
        val <= 32'd0 - ctl.arg;
        hex <= ctl.hex;
      end
      fde_pkg::DP_MUL: begin
        prod <= 64'(val) * 64'(fde_pkg::DEC_RECIP);
      end
      fde_pkg::DP_DIV: begin
        dig_mem[cnt] <= rem;
        val          <= q;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/format_directive_expander_core.sv @@
// a plain or single-character item goes from idle through dispatch, any handler step and
// the end step; a number runs a multiply and a divide step per digit (divide by ten for
// decimal, a nibble shift for hex), then pops one digit per cycle while out_stall allows.
// throughput: one request at a time; an output register held by out_stall stalls the sequencer.
// reset (rst, synchronous, active high): sequencer to idle, pending percent and
// character tally cleared, output register empty.
module format_directive_expander_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         fmt_byte,
  input  logic [31:0]        arg_word,
  input  logic               end_of_format,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               is_total,
  output logic signed [31:0] total_chars,
  output logic               run_end
);

  // micro-program: one control word per step
  function automatic fde_pkg::uword_t ucode(input fde_pkg::uaddr_t a);
    fde_pkg::uword_t w;
    w = '{emit: fde_pkg::E_NONE, op: fde_pkg::DP_NONE, hex: 1'b0, fin: 1'b0,
          upd_pct: 1'b0, seq: fde_pkg::SEQ_JUMP, target: fde_pkg::U_IDLE};
    unique case (a)
      // wait for a request
      fde_pkg::U_IDLE: begin
        w.seq    = fde_pkg::SEQ_WAIT;
        w.target = fde_pkg::U_DISP;
      end
      // classify the byte, update the pending-percent flag
      fde_pkg::U_DISP: begin
        w.seq     = fde_pkg::SEQ_DISP;
        w.upd_pct = 1'b1;
      end
      fde_pkg::U_ECHO: begin
        w.emit   = fde_pkg::E_FMT;
        w.fin    = 1'b1;
        w.target = fde_pkg::U_END;
      end
      fde_pkg::U_ARGC: begin
        w.emit   = fde_pkg::E_ARG;
        w.fin    = 1'b1;
        w.target = fde_pkg::U_END;
      end
      fde_pkg::U_LITPCT: begin
        w.emit   = fde_pkg::E_PCT;
        w.fin    = 1'b1;
        w.target = fde_pkg::U_END;
      end
      // minus sign goes out while the magnitude loads
      fde_pkg::U_NEG: begin
        w.emit   = fde_pkg::E_MINUS;
        w.op     = fde_pkg::DP_LOAD_NEG;
        w.target = fde_pkg::U_MUL;
      end
      fde_pkg::U_DEC: begin
        w.op     = fde_pkg::DP_LOAD;
        w.target = fde_pkg::U_MUL;
      end
      fde_pkg::U_HEX: begin
        w.op     = fde_pkg::DP_LOAD;
        w.hex    = 1'b1;
        w.target = fde_pkg::U_MUL;
      end
      // digit loop, least significant first into the digit stack
      fde_pkg::U_MUL: begin
        w.op     = fde_pkg::DP_MUL;
        w.target = fde_pkg::U_DIV;
      end
      fde_pkg::U_DIV: begin
        w.op     = fde_pkg::DP_DIV;
        w.seq    = fde_pkg::SEQ_IF_MORE;
        w.target = fde_pkg::U_MUL;
      end
      // pop digits most significant first
      fde_pkg::U_EMIT: begin
        w.emit   = fde_pkg::E_DIGIT;
        w.op     = fde_pkg::DP_POP;
        w.seq    = fde_pkg::SEQ_IF_DIGITS;
        w.target = fde_pkg::U_EMIT;
      end
      // count result on the last format byte
      fde_pkg::U_END: begin
        w.emit   = fde_pkg::E_TOTAL;
        w.target = fde_pkg::U_IDLE;
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  // dispatch map from pending flag and byte to the handler step
  function automatic fde_pkg::uaddr_t dispatch(input logic pend, input logic [7:0] b,
                                               input logic neg);
    fde_pkg::uaddr_t t;
    t = fde_pkg::U_ECHO;
    if (!pend) begin
      if (b == fde_pkg::CH_PCT) begin
        t = fde_pkg::U_END;
      end
    end else begin
      priority if (b == fde_pkg::CH_D) begin
        t = neg ? fde_pkg::U_NEG : fde_pkg::U_DEC;
      end else if (b == fde_pkg::CH_U) begin
        t = fde_pkg::U_DEC;
      end else if (b == fde_pkg::CH_X) begin
        t = fde_pkg::U_HEX;
      end else if (b == fde_pkg::CH_C) begin
        t = fde_pkg::U_ARGC;
      end else if (b == fde_pkg::CH_PCT) begin
        t = fde_pkg::U_LITPCT;
      end else if (b == fde_pkg::CH_S) begin
        t = fde_pkg::U_END;
      end else begin
        t = fde_pkg::U_ECHO;
      end
    end
    return t;
  endfunction

  // sequencer and request registers
  fde_pkg::uaddr_t pc;
  fde_pkg::uaddr_t pc_next;
  logic            pct;
  logic [30:0]     tally;
  logic [7:0]      fmt_q;
  logic [31:0]     arg_q;
  logic            last_q;

  fde_pkg::uword_t   uw;
  fde_pkg::dp_ctl_t  ctl;
  fde_pkg::dp_stat_t st;

  logic       emit_on;
  logic       out_free;
  logic       advance;
  logic       in_take;
  logic       load;
  logic [7:0] ch;
  logic       fin_now;

  assign uw = ucode(pc);

  // the count result only goes out on the last format byte
  assign emit_on  = (uw.emit != fde_pkg::E_NONE) &&
                    !((uw.emit == fde_pkg::E_TOTAL) && !last_q);
  // output register can take a character when empty or being drained
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (pc != fde_pkg::U_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign advance  = (uw.seq == fde_pkg::SEQ_WAIT) ? in_valid : (!emit_on || out_free);
  assign load     = advance && emit_on;

  // datapath only moves when the step retires
  assign ctl.op  = advance ? uw.op : fde_pkg::DP_NONE;
  assign ctl.hex = uw.hex;
  assign ctl.arg = arg_q;

  fde_digit_unit u_digits (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .st  (st)
  );

  // next step
  always_comb begin
    pc_next = pc;
    if (advance) begin
      unique case (uw.seq)
        fde_pkg::SEQ_WAIT:      pc_next = uw.target;
        fde_pkg::SEQ_DISP:      pc_next = dispatch(pct, fmt_q, arg_q[31]);
        fde_pkg::SEQ_JUMP:      pc_next = uw.target;
        fde_pkg::SEQ_IF_MORE:   pc_next = st.more ? uw.target : pc + 1'b1;
        fde_pkg::SEQ_IF_DIGITS: pc_next = !st.last_digit ? uw.target : pc + 1'b1;
        default:                pc_next = fde_pkg::U_IDLE;
      endcase
    end
  end

  // character select for the output register
  always_comb begin
    unique case (uw.emit)
      fde_pkg::E_FMT:   ch = fmt_q;
      fde_pkg::E_ARG:   ch = arg_q[7:0];
      fde_pkg::E_PCT:   ch = fde_pkg::CH_PCT;
      fde_pkg::E_MINUS: ch = fde_pkg::CH_MINUS;
      fde_pkg::E_DIGIT: ch = st.digit_ch;
      default:          ch = 8'h00;
    endcase
  end

  // marks the last result of this request
  assign fin_now = (uw.emit == fde_pkg::E_TOTAL) ||
                   (uw.fin && !last_q) ||
                   ((uw.emit == fde_pkg::E_DIGIT) && st.last_digit && !last_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= fde_pkg::U_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // pending percent: set or cleared by dispatch, dropped by the count result
  always_ff @(posedge clk) begin
    if (rst) begin
      pct <= 1'b0;
    end else if (advance && uw.upd_pct) begin
      pct <= !pct && (fmt_q == fde_pkg::CH_PCT);
    end else if (load && (uw.emit == fde_pkg::E_TOTAL)) begin
      pct <= 1'b0;
    end
  end

  // saturating character tally, cleared once the count goes out
  always_ff @(posedge clk) begin
    if (rst) begin
      tally <= '0;
    end else if (load && (uw.emit == fde_pkg::E_TOTAL)) begin
      tally <= '0;
    end else if (load && (tally != '1)) begin
      tally <= tally + 1'b1;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      fmt_q  <= fmt_byte;
      arg_q  <= arg_word;
      last_q <= end_of_format;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= ch;
      is_total <= (uw.emit == fde_pkg::E_TOTAL);
      run_end  <= fin_now;
      if (uw.emit == fde_pkg::E_TOTAL) begin
        total_chars <= (tally == '0) ? 32'shffff_ffff : $signed({1'b0, tally});
      end else begin
        total_chars <= 32'sd0;
      end
    end
  end

`ifndef SYNTHESIS
  a_take_dispatch: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (pc == fde_pkg::U_DISP))
    else $error("accepted request did not reach dispatch");

  a_total_clears: assert property (@(posedge clk) disable iff (rst)
    (load && (uw.emit == fde_pkg::E_TOTAL)) |=> ((tally == '0) && !pct))
    else $error("count result left state behind");

  a_total_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_total) |-> (run_end && (out_byte == 8'h00)))
    else $error("count result malformed");

  a_digits_done: assert property (@(posedge clk) disable iff (rst)
    ((pc == fde_pkg::U_EMIT) && advance && st.last_digit) |=> (pc == fde_pkg::U_END))
    else $error("digit pop overran the stack");
`endif

endmodule
